>>> rtl/sgp_pkg.sv
// Shared types and constants for the smoothed gain/pan unit with peak meter.
package sgp_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int RAMP_W      = 40;
  localparam int STEP_W      = 41;
  localparam int GOAL_W      = 18;
  localparam int CNT_W       = 16;
  localparam int ROM_W       = 17;
  localparam int MA_W        = 27;
  localparam int MB_W        = 28;
  localparam int ACC_W       = 56;
  localparam int DIGIT_W     = 4;
  localparam int MUL_DIGITS  = MB_W / DIGIT_W;
  localparam int DIV_BITS    = RAMP_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [MB_W-1:0] DECAY_Q16   = MB_W'(51118);

  localparam logic [1:0] RAMP_GAIN  = 2'd0;
  localparam logic [1:0] RAMP_LEFT  = 2'd1;
  localparam logic [1:0] RAMP_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    CFG_TARGET_GAIN  = 3'd0,
    CFG_PAN_POSITION = 3'd1,
    CFG_MUTE         = 3'd2,
    CFG_MONO_MODE    = 3'd3,
    CFG_RAMP_STEPS   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROM_A,
    ST_ROM_B,
    ST_ROM_C,
    ST_TGT,
    ST_DIV,
    ST_NEXT,
    ST_MUL_GL,
    ST_MUL_GR,
    ST_MUL_SL,
    ST_MUL_SR,
    ST_PEAK,
    ST_MUL_MT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          first_of_block;
    logic                          last_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [SAMPLE_BITS-1:0]        meter_level;
    logic                          meter_valid;
  } out_item_t;

endpackage

>>> rtl/smoothed_gain_pan_with_peak_meter_unit.sv
// Gain and constant-power pan with linear ramps, saturation and a decaying peak meter.
// Work per request: a mono sample skips the pan multiplies, the last sample of a block
//   adds a meter update, and a block start adds table reads and a serial divide per changed ramp target.
// Throughput: one request at a time; the 4-bit-per-cycle multiplier
//   and the 1-bit-per-cycle divider do the arithmetic serially.
// Reset (synchronous, active low): registers take their defaults, ramps sit on their
//   targets at centre pan, meter and peak clear, no result pending.
module smoothed_gain_pan_with_peak_meter_unit #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sgp_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sgp_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [17:0]          cfg_data
);
  import sgp_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = IDX_W + 17;

  typedef logic [ROM_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  function automatic logic [ROM_W-1:0] sin_q16(input int k);
    longint unsigned x;
    longint unsigned term;
    longint signed   sum;
    x = longint'(k) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
    sum = longint'(x);
    term = x;
    term = ((term * x) >> 30) * x >> 30; term = term / 6;   sum = sum - longint'(term);
    term = ((term * x) >> 30) * x >> 30; term = term / 20;  sum = sum + longint'(term);
    term = ((term * x) >> 30) * x >> 30; term = term / 42;  sum = sum - longint'(term);
    term = ((term * x) >> 30) * x >> 30; term = term / 72;  sum = sum + longint'(term);
    term = ((term * x) >> 30) * x >> 30; term = term / 110; sum = sum - longint'(term);
    term = ((term * x) >> 30) * x >> 30; term = term / 156; sum = sum + longint'(term);
    term = ((term * x) >> 30) * x >> 30; term = term / 210; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    sum = (sum + 8192) >>> 14;
    if (sum > 65536) sum = 65536;
    return ROM_W'(sum);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) t[k] = sin_q16(k);
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();
  localparam int CTR_RAW = (32768 * SINE_TABLE_DEPTH + 32768) >> 16;
  localparam int CTR_IDX = (CTR_RAW > SINE_TABLE_DEPTH) ? SINE_TABLE_DEPTH : CTR_RAW;
  localparam logic [ROM_W-1:0] RST_RG = SINE_ROM[CTR_IDX];
  localparam logic [ROM_W-1:0] RST_LG = SINE_ROM[SINE_TABLE_DEPTH - CTR_IDX];
  localparam logic [GOAL_W-1:0] RST_GAIN = GOAL_W'(65536);

  state_t state_r, state_nxt;

  logic [GOAL_W-1:0] tgt_gain_r;
  logic [15:0]       pan_pos_r;
  logic              mute_r;
  logic              mono_r;
  logic [CNT_W-1:0]  ramp_steps_r;

  in_item_t item_r;

  logic [RAMP_W-1:0]        now_r  [3];
  logic signed [STEP_W-1:0] step_r [3];
  logic [GOAL_W-1:0]        goal_r [3];
  logic [CNT_W-1:0]         cnt_r  [3];
  logic [RAMP_W-1:0]        nn     [3];

  logic [IDX_W-1:0] pan_idx_r;
  logic [IDX_W-1:0] rom_addr;
  logic [ROM_W-1:0] rom_rd_r;
  logic [ROM_W-1:0] rg_r;
  logic [ROM_W-1:0] lg_r;
  logic [1:0]       rsel_r;

  logic [DIV_BITS-1:0] dq_r;
  logic [CNT_W-1:0]    drem_r;
  logic [5:0]          dcnt_r;
  logic                dneg_r;

  logic [MA_W-1:0]  ma_r;
  logic [MB_W-1:0]  mb_r;
  logic [ACC_W-1:0] acc_r;
  logic [2:0]       mcnt_r;
  logic             mul_ld;
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic             mul_done;

  logic [MA_W-1:0]        compr_r;
  logic [SAMPLE_BITS-1:0] lo_mag_r, ro_mag_r, peak_r, meter_r;
  logic                   mvalid_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  // combinational helpers
  logic [15:0]             pan_u;
  logic [PW-1:0]           pan_prod;
  logic [IDX_W:0]          idx_raw;
  logic [GOAL_W-1:0]       new_goal;
  logic                    goal_same;
  logic [STEP_W-1:0]       diff;
  logic [STEP_W-1:0]       diff_mag;
  logic [CNT_W:0]          rem_sh;
  logic                    rem_ge;
  logic [ACC_W-1:0]        acc_rnd;
  logic [31:0]             sc;
  logic [SAMPLE_BITS-1:0]  mag_l, mag_r;
  logic [SAMPLE_BITS-1:0]  sat_l, sat_r;
  logic [SAMPLE_BITS-1:0]  pk1, pk2, dec;
  logic                    out_free;

  function automatic logic [SAMPLE_BITS-1:0] abs_s(input logic [SAMPLE_BITS-1:0] s);
    return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat_mag(input logic [31:0] r, input logic neg);
    logic [31:0] lim;
    lim = neg ? 32'(1 << (SAMPLE_BITS - 1)) : 32'((1 << (SAMPLE_BITS - 1)) - 1);
    return (r > lim) ? lim[SAMPLE_BITS-1:0] : r[SAMPLE_BITS-1:0];
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign pan_u    = pan_pos_r ^ 16'h8000;
  assign pan_prod = PW'(pan_u) * PW'(SINE_TABLE_DEPTH) + PW'(32768);
  assign idx_raw  = pan_prod[PW-1:16];

  assign mag_l    = abs_s(item_r.left_sample);
  assign mag_r    = abs_s(item_r.right_sample);
  assign acc_rnd  = acc_r + ACC_W'(1 << 23);
  assign sc       = acc_rnd[55:24];
  assign sat_l    = sat_mag(sc, item_r.left_sample[SAMPLE_BITS-1]);
  assign sat_r    = sat_mag(sc, item_r.right_sample[SAMPLE_BITS-1]);
  assign mul_done = (mcnt_r == 3'd0);
  assign pk1      = (lo_mag_r > peak_r) ? lo_mag_r : peak_r;
  assign pk2      = (ro_mag_r > pk1) ? ro_mag_r : pk1;
  assign dec      = acc_r[16 +: SAMPLE_BITS];

  always_comb begin
    case (rsel_r)
      RAMP_GAIN: new_goal = mute_r ? '0 : tgt_gain_r;
      RAMP_LEFT: new_goal = GOAL_W'(lg_r);
      default:   new_goal = GOAL_W'(rg_r);
    endcase
  end
  assign goal_same = (new_goal == goal_r[rsel_r]);
  assign diff      = {1'b0, new_goal, 22'd0} - {1'b0, now_r[rsel_r]};
  assign diff_mag  = diff[STEP_W-1] ? (~diff + 1'b1) : diff;
  assign rem_sh    = {drem_r, dq_r[DIV_BITS-1]};
  assign rem_ge    = (rem_sh >= {1'b0, ramp_steps_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cnt_r[i] == '0) begin
        nn[i] = now_r[i];
      end else if (cnt_r[i] == CNT_W'(1)) begin
        nn[i] = {goal_r[i], 22'd0};
      end else begin
        nn[i] = now_r[i] + step_r[i][RAMP_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_ld    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rom_addr  = pan_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type || in_data.first_of_block) ? ST_ROM_A : ST_NEXT;
        end
      end
      ST_ROM_A: state_nxt = ST_ROM_B;
      ST_ROM_B: begin
        rom_addr  = IDX_W'(SINE_TABLE_DEPTH) - pan_idx_r;
        state_nxt = ST_ROM_C;
      end
      ST_ROM_C: state_nxt = item_r.req_type ? ST_OUT : ST_TGT;
      ST_TGT: begin
        if (goal_same || ramp_steps_r == '0) begin
          state_nxt = (rsel_r == RAMP_RIGHT) ? ST_NEXT : ST_TGT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_r == '0) state_nxt = (rsel_r == RAMP_RIGHT) ? ST_NEXT : ST_TGT;
      end
      ST_NEXT: begin
        mul_ld = 1'b1;
        if (mono_r) begin
          mul_a     = MA_W'(nn[RAMP_GAIN][RAMP_W-1:14]);
          mul_b     = MB_W'(mag_l);
          state_nxt = ST_MUL_SL;
        end else begin
          mul_a     = MA_W'(nn[RAMP_GAIN][RAMP_W-1:14]);
          mul_b     = MB_W'(nn[RAMP_LEFT][RAMP_W-1:14]);
          state_nxt = ST_MUL_GL;
        end
      end
      ST_MUL_GL: begin
        if (mul_done) begin
          mul_ld    = 1'b1;
          mul_a     = MA_W'(now_r[RAMP_GAIN][RAMP_W-1:14]);
          mul_b     = MB_W'(now_r[RAMP_RIGHT][RAMP_W-1:14]);
          state_nxt = ST_MUL_GR;
        end
      end
      ST_MUL_GR: begin
        if (mul_done) begin
          mul_ld    = 1'b1;
          mul_a     = compr_r;
          mul_b     = MB_W'(mag_l);
          state_nxt = ST_MUL_SL;
        end
      end
      ST_MUL_SL: begin
        if (mul_done) begin
          if (mono_r) begin
            state_nxt = ST_PEAK;
          end else begin
            mul_ld    = 1'b1;
            mul_a     = compr_r;
            mul_b     = MB_W'(mag_r);
            state_nxt = ST_MUL_SR;
          end
        end
      end
      ST_MUL_SR: if (mul_done) state_nxt = ST_PEAK;
      ST_PEAK: begin
        if (item_r.last_of_block) begin
          mul_ld    = 1'b1;
          mul_a     = MA_W'(meter_r);
          mul_b     = DECAY_Q16;
          state_nxt = ST_MUL_MT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_MUL_MT: if (mul_done) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_gain_r   <= RST_GAIN;
      pan_pos_r    <= '0;
      mute_r       <= 1'b0;
      mono_r       <= 1'b0;
      ramp_steps_r <= CNT_W'(960);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_GAIN:  tgt_gain_r   <= cfg_data;
        CFG_PAN_POSITION: pan_pos_r    <= cfg_data[15:0];
        CFG_MUTE:         mute_r       <= cfg_data[0];
        CFG_MONO_MODE:    mono_r       <= cfg_data[0];
        CFG_RAMP_STEPS:   ramp_steps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pan table index and registered table read
  always_ff @(posedge clk) begin
    pan_idx_r <= (idx_raw > (IDX_W + 1)'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH)
                                                            : idx_raw[IDX_W-1:0];
    rom_rd_r  <= SINE_ROM[rom_addr];
  end

  // digit-serial multiplier, four multiplier bits a cycle, MSB first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else if (mul_ld) begin
      ma_r   <= mul_a;
      mb_r   <= mul_b;
      acc_r  <= '0;
      mcnt_r <= 3'(MUL_DIGITS);
    end else if (mcnt_r != '0) begin
      acc_r  <= (acc_r << DIGIT_W) + ACC_W'(ma_r) * ACC_W'(mb_r[MB_W-1 -: DIGIT_W]);
      mb_r   <= mb_r << DIGIT_W;
      mcnt_r <= mcnt_r - 1'b1;
    end
  end

  // ramps, divider and metering
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r[RAMP_GAIN]   <= {RST_GAIN, 22'd0};
      now_r[RAMP_LEFT]   <= {1'b0, RST_LG, 22'd0};
      now_r[RAMP_RIGHT]  <= {1'b0, RST_RG, 22'd0};
      goal_r[RAMP_GAIN]  <= RST_GAIN;
      goal_r[RAMP_LEFT]  <= GOAL_W'(RST_LG);
      goal_r[RAMP_RIGHT] <= GOAL_W'(RST_RG);
      for (int i = 0; i < 3; i++) begin
        step_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      peak_r      <= '0;
      meter_r     <= '0;
      mvalid_r    <= 1'b0;
      dcnt_r      <= '0;
      rsel_r      <= RAMP_GAIN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_OUT && out_free) || (out_valid_r && !out_ready);
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r   <= in_data;
            mvalid_r <= 1'b0;
            ro_mag_r <= '0;
          end
        end
        ST_ROM_B: rg_r <= rom_rd_r;
        ST_ROM_C: begin
          lg_r   <= rom_rd_r;
          rsel_r <= RAMP_GAIN;
          peak_r <= '0;
          if (item_r.req_type) begin
            now_r[RAMP_GAIN]   <= {tgt_gain_r, 22'd0};
            now_r[RAMP_LEFT]   <= {1'b0, rom_rd_r, 22'd0};
            now_r[RAMP_RIGHT]  <= {1'b0, rg_r, 22'd0};
            goal_r[RAMP_GAIN]  <= tgt_gain_r;
            goal_r[RAMP_LEFT]  <= GOAL_W'(rom_rd_r);
            goal_r[RAMP_RIGHT] <= GOAL_W'(rg_r);
            for (int i = 0; i < 3; i++) begin
              step_r[i] <= '0;
              cnt_r[i]  <= '0;
            end
            meter_r  <= '0;
            lo_mag_r <= '0;
            mvalid_r <= 1'b1;
          end
        end
        ST_TGT: begin
          if (goal_same) begin
            rsel_r <= rsel_r + 1'b1;
          end else if (ramp_steps_r == '0) begin
            goal_r[rsel_r] <= new_goal;
            now_r[rsel_r]  <= {new_goal, 22'd0};
            step_r[rsel_r] <= '0;
            cnt_r[rsel_r]  <= '0;
            rsel_r         <= rsel_r + 1'b1;
          end else begin
            goal_r[rsel_r] <= new_goal;
            cnt_r[rsel_r]  <= ramp_steps_r;
            dneg_r         <= diff[STEP_W-1];
            dq_r           <= diff_mag[DIV_BITS-1:0];
            drem_r         <= '0;
            dcnt_r         <= 6'(DIV_BITS);
          end
        end
        ST_DIV: begin
          if (dcnt_r != '0) begin
            drem_r <= rem_ge ? CNT_W'(rem_sh - {1'b0, ramp_steps_r}) : rem_sh[CNT_W-1:0];
            dq_r   <= {dq_r[DIV_BITS-2:0], rem_ge};
            dcnt_r <= dcnt_r - 1'b1;
          end else begin
            step_r[rsel_r] <= dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
            rsel_r         <= rsel_r + 1'b1;
          end
        end
        ST_NEXT: begin
          for (int i = 0; i < 3; i++) begin
            now_r[i] <= nn[i];
            if (cnt_r[i] != '0) cnt_r[i] <= cnt_r[i] - 1'b1;
          end
        end
        ST_MUL_GL: if (mul_done) compr_r <= MA_W'(sc);
        ST_MUL_GR: if (mul_done) compr_r <= MA_W'(sc);
        ST_MUL_SL: if (mul_done) lo_mag_r <= sat_l;
        ST_MUL_SR: if (mul_done) ro_mag_r <= sat_r;
        ST_PEAK: begin
          // on the last sample of a block, hand the peak to the meter update and clear it
          peak_r <= item_r.last_of_block ? '0 : pk2;
          if (item_r.last_of_block) compr_r <= MA_W'(pk2);
        end
        ST_MUL_MT: begin
          if (mul_done) begin
            meter_r  <= (compr_r[SAMPLE_BITS-1:0] > dec) ? compr_r[SAMPLE_BITS-1:0] : dec;
            mvalid_r <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_r.left_out    <= item_r.left_sample[SAMPLE_BITS-1] ? (~lo_mag_r + 1'b1)
                                                                   : lo_mag_r;
            out_r.right_out   <= item_r.right_sample[SAMPLE_BITS-1] ? (~ro_mag_r + 1'b1)
                                                                    : ro_mag_r;
            out_r.meter_level <= meter_r;
            out_r.meter_valid <= mvalid_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sgp_checker.sv
// Port-level checks for the smoothed gain/pan unit, bound to its top level.
module sgp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind smoothed_gain_pan_with_peak_meter_unit sgp_checker u_sgp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
